// ===== rtl/lbgct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbgct_pkg
// shared constants for the lbg codebook trainer: sizes, function codes,
// register indexes and reset values
// ----------------------------------------------------------------------------
package lbgct_pkg;

   localparam int MAX_TRAIN_DEF     = 4096;
   localparam int MAX_DIM_DEF       = 16;
   localparam int MAX_CODEWORDS_DEF = 256;

   // request function codes
   localparam logic [1:0] FN_LOAD_TRAIN = 2'd0;
   localparam logic [1:0] FN_LOAD_CW    = 2'd1;
   localparam logic [1:0] FN_RUN        = 2'd2;
   localparam logic [1:0] FN_READ_CW    = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_VECTOR_DIM     = 3'd0;
   localparam logic [2:0] CSR_TRAIN_COUNT    = 3'd1;
   localparam logic [2:0] CSR_CODEWORD_COUNT = 3'd2;
   localparam logic [2:0] CSR_EPS_Q16        = 3'd3;
   localparam logic [2:0] CSR_MAX_PASSES     = 3'd4;

   // register reset values
   localparam logic [4:0]  RST_VECTOR_DIM     = 5'd4;
   localparam logic [12:0] RST_TRAIN_COUNT    = 13'd4096;
   localparam logic [8:0]  RST_CODEWORD_COUNT = 9'd16;
   localparam logic [15:0] RST_EPS_Q16        = 16'd1;
   localparam logic [9:0]  RST_MAX_PASSES     = 10'd255;

   localparam logic [33:0] DIST_MAX = {34{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/lbg_codebook_trainer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_codebook_trainer
// vector quantiser codebook training by the Linde-Buzo-Gray method, run by a
// small sequencer around one distance/accumulate path and a serial divider
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  func, vec_index, elem_index, value
//  rsp      out        rsp_valid/rsp_stall  elem_value, distortion, passes,
//                                           converged, hit_limit
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  loads are written at their beat; a codeword read answers through the
//  registered store read and then the result register; a run pass steps
//  through clear, assign, judge and update over N vectors, K codewords and
//  D elements; each element costs a registered read of the stores
//  reset idles the sequencer, resets config registers, clears result valid
//  req_stall stays high while a run or read is at work or a result waits
// ----------------------------------------------------------------------------
module lbg_codebook_trainer
   import lbgct_pkg::*;
#(
   parameter int MAX_TRAIN     = MAX_TRAIN_DEF,
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int MAX_CODEWORDS = MAX_CODEWORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [11:0] req_vec_index,
   input  wire logic [3:0]  req_elem_index,
   input  wire logic [7:0]  req_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_elem_value,
   output      logic [33:0] rsp_distortion,
   output      logic [9:0]  rsp_passes,
   output      logic        rsp_converged,
   output      logic        rsp_hit_limit,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int TRAIN_W = $clog2(MAX_TRAIN);
   localparam int CW_W    = $clog2(MAX_CODEWORDS);
   localparam int CNT_W   = $clog2(MAX_TRAIN + 1);
   localparam int SUM_W   = CNT_W + 8;
   localparam int ACC_W   = $clog2(MAX_DIM * 65025 + 1);
   localparam int STEP_W  = $clog2(SUM_W);
   localparam int TR_DEPTH = 1 << (TRAIN_W + DIM_W);
   localparam int CB_DEPTH = 1 << (CW_W + DIM_W);
   localparam int CN_DEPTH = 1 << CW_W;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RDCB  = 5'd1;
   localparam logic [4:0] S_CLR   = 5'd2;
   localparam logic [4:0] S_A_RD  = 5'd3;
   localparam logic [4:0] S_A_ACC = 5'd4;
   localparam logic [4:0] S_A_CMP = 5'd5;
   localparam logic [4:0] S_U_CNT = 5'd6;
   localparam logic [4:0] S_U_INC = 5'd7;
   localparam logic [4:0] S_U_RD  = 5'd8;
   localparam logic [4:0] S_U_WR  = 5'd9;
   localparam logic [4:0] S_J_LO  = 5'd10;
   localparam logic [4:0] S_J_HI  = 5'd11;
   localparam logic [4:0] S_J_CMP = 5'd12;
   localparam logic [4:0] S_D_CNT = 5'd13;
   localparam logic [4:0] S_D_CHK = 5'd14;
   localparam logic [4:0] S_D_RD  = 5'd15;
   localparam logic [4:0] S_D_LD  = 5'd16;
   localparam logic [4:0] S_D_DIV = 5'd17;
   localparam logic [4:0] S_D_WR  = 5'd18;
   localparam logic [4:0] S_DONE  = 5'd19;

   // configuration
   logic [4:0]  cfg_dim_ff;
   logic [12:0] cfg_ntr_ff;
   logic [8:0]  cfg_ncw_ff;
   logic [15:0] cfg_eps_ff;
   logic [9:0]  cfg_lim_ff;

   // sequencer
   logic [4:0]         state_ff, state_in;
   logic [DIM_W-1:0]   dim_last_ff, dim_last_in;
   logic [TRAIN_W-1:0] ntr_last_ff, ntr_last_in;
   logic [CW_W-1:0]    ncw_last_ff, ncw_last_in;
   logic [9:0]         lim_ff, lim_in;
   logic [DIM_W-1:0]   e_ff, e_in;
   logic [TRAIN_W-1:0] t_ff, t_in;
   logic [CW_W-1:0]    c_ff, c_in;
   logic [CW_W-1:0]    best_ff, best_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   best_d_ff, best_d_in;
   logic [33:0]        total_ff, total_in;
   logic [33:0]        prev_ff, prev_in;
   logic [9:0]         pass_ff, pass_in;
   logic [32:0]        prod_lo_ff, prod_lo_in;
   logic [32:0]        prod_hi_ff, prod_hi_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rd_ok_ff, rd_ok_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_elem_ff, rsp_elem_in;
   logic [33:0] rsp_dist_ff, rsp_dist_in;
   logic [9:0]  rsp_pass_ff, rsp_pass_in;
   logic        rsp_conv_ff, rsp_conv_in;
   logic        rsp_lim_ff, rsp_lim_in;

   // stores
   logic [7:0]       train_mem [0:TR_DEPTH-1];
   logic [7:0]       cb_mem    [0:CB_DEPTH-1];
   logic [SUM_W-1:0] sum_mem   [0:CB_DEPTH-1];
   logic [CNT_W-1:0] cnt_mem   [0:CN_DEPTH-1];

   logic [7:0]       tr_rd_ff, cb_rd_ff;
   logic [SUM_W-1:0] sum_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;

   logic                    tr_we, cb_we, sum_we, cnt_we;
   logic [TRAIN_W+DIM_W-1:0] tr_waddr, tr_raddr;
   logic [CW_W+DIM_W-1:0]   cb_waddr, cb_raddr, sum_waddr, sum_raddr;
   logic [CW_W-1:0]         cnt_waddr, cnt_raddr;
   logic [7:0]              cb_wdata;
   logic [SUM_W-1:0]        sum_wdata;
   logic [CNT_W-1:0]        cnt_wdata;

   logic              accept;
   logic              tr_in_range, cw_in_range;
   logic signed [8:0] diff;
   logic [15:0]       sq;
   logic [34:0]       tot_sum;
   logic [49:0]       lhs, rhs;
   logic              conv;
   logic [CNT_W:0]    rem_sh;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_elem_value = rsp_elem_ff;
   assign rsp_distortion = rsp_dist_ff;
   assign rsp_passes     = rsp_pass_ff;
   assign rsp_converged  = rsp_conv_ff;
   assign rsp_hit_limit  = rsp_lim_ff;

   assign tr_in_range = (int'(req_vec_index) < MAX_TRAIN) && (int'(req_elem_index) < MAX_DIM);
   assign cw_in_range = (int'(req_vec_index) < MAX_CODEWORDS)
                        && (int'(req_elem_index) < MAX_DIM);

   assign diff    = $signed({1'b0, tr_rd_ff}) - $signed({1'b0, cb_rd_ff});
   assign sq      = 16'(diff * diff);
   assign tot_sum = {1'b0, total_ff} + 35'(best_d_ff);
   assign lhs     = {prev_ff - total_ff, 16'd0};
   assign rhs     = {prod_hi_ff, 17'd0} + 50'(prod_lo_ff);
   assign conv    = (total_ff == 34'd0) || (total_ff > prev_ff) || (lhs < rhs);
   assign rem_sh  = {rem_ff, quot_ff[SUM_W-1]};

   // store addressing
   assign tr_waddr  = {TRAIN_W'(req_vec_index), DIM_W'(req_elem_index)};
   assign tr_raddr  = {t_ff, e_ff};
   assign cb_waddr  = (state_ff == S_IDLE) ? {CW_W'(req_vec_index), DIM_W'(req_elem_index)}
                                           : {c_ff, e_ff};
   assign cb_raddr  = (state_ff == S_IDLE) ? {CW_W'(req_vec_index), DIM_W'(req_elem_index)}
                                           : {c_ff, e_ff};
   assign cb_wdata  = (state_ff == S_IDLE) ? req_value : quot_ff[7:0];
   assign sum_waddr = (state_ff == S_CLR) ? {c_ff, e_ff} : {best_ff, e_ff};
   assign sum_raddr = (state_ff == S_U_RD) ? {best_ff, e_ff} : {c_ff, e_ff};
   assign sum_wdata = (state_ff == S_CLR) ? '0 : sum_rd_ff + SUM_W'(tr_rd_ff);
   assign cnt_waddr = (state_ff == S_CLR) ? c_ff : best_ff;
   assign cnt_raddr = (state_ff == S_U_CNT) ? best_ff : c_ff;
   assign cnt_wdata = (state_ff == S_CLR) ? '0 : cnt_rd_ff + CNT_W'(1);

   always_comb begin
      int vd, nt, nc;
      vd = int'(cfg_dim_ff);
      nt = int'(cfg_ntr_ff);
      nc = int'(cfg_ncw_ff);

      state_in    = state_ff;
      dim_last_in = dim_last_ff;
      ntr_last_in = ntr_last_ff;
      ncw_last_in = ncw_last_ff;
      lim_in      = lim_ff;
      e_in        = e_ff;
      t_in        = t_ff;
      c_in        = c_ff;
      best_in     = best_ff;
      acc_in      = acc_ff;
      best_d_in   = best_d_ff;
      total_in    = total_ff;
      prev_in     = prev_ff;
      pass_in     = pass_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      step_in     = step_ff;
      rd_ok_in    = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_elem_in = rsp_elem_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_pass_in = rsp_pass_ff;
      rsp_conv_in = rsp_conv_ff;
      rsp_lim_in  = rsp_lim_ff;
      tr_we  = 1'b0;
      cb_we  = 1'b0;
      sum_we = 1'b0;
      cnt_we = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FN_LOAD_TRAIN: tr_we = tr_in_range;
                  FN_LOAD_CW:    cb_we = cw_in_range;
                  FN_READ_CW: begin
                     rd_ok_in = cw_in_range;
                     state_in = S_RDCB;
                  end
                  FN_RUN: begin
                     dim_last_in = DIM_W'((vd < 1) ? 0 : ((vd > MAX_DIM) ? MAX_DIM - 1 : vd - 1));
                     ntr_last_in = TRAIN_W'((nt < 1) ? 0
                                          : ((nt > MAX_TRAIN) ? MAX_TRAIN - 1 : nt - 1));
                     ncw_last_in = CW_W'((nc < 1) ? 0
                                       : ((nc > MAX_CODEWORDS) ? MAX_CODEWORDS - 1 : nc - 1));
                     lim_in   = (cfg_lim_ff == 10'd0) ? 10'd1 : cfg_lim_ff;
                     prev_in  = DIST_MAX;
                     pass_in  = '0;
                     total_in = '0;
                     acc_in   = '0;
                     c_in     = '0;
                     e_in     = '0;
                     t_in     = '0;
                     state_in = S_CLR;
                  end
                  default: ;
               endcase
            end
         end
         S_RDCB: begin
            rsp_valid_in = 1'b1;
            rsp_elem_in  = rd_ok_ff ? cb_rd_ff : 8'd0;
            rsp_dist_in  = '0;
            rsp_pass_in  = '0;
            rsp_conv_in  = 1'b0;
            rsp_lim_in   = 1'b0;
            state_in     = S_IDLE;
         end
         // zero the member sums and counts of the codewords in use
         S_CLR: begin
            sum_we = 1'b1;
            cnt_we = 1'b1;
            if (e_ff == dim_last_ff) begin
               e_in = '0;
               if (c_ff == ncw_last_ff) begin
                  c_in     = '0;
                  t_in     = '0;
                  state_in = S_A_RD;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_A_RD: state_in = S_A_ACC;
         S_A_ACC: begin
            acc_in = acc_ff + ACC_W'(sq);
            if (e_ff == dim_last_ff) begin
               state_in = S_A_CMP;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_A_RD;
            end
         end
         // ties keep the lower index
         S_A_CMP: begin
            if ((c_ff == '0) || (acc_ff < best_d_ff)) begin
               best_in   = c_ff;
               best_d_in = acc_ff;
            end
            acc_in = '0;
            e_in   = '0;
            if (c_ff == ncw_last_ff) begin
               state_in = S_U_CNT;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_A_RD;
            end
         end
         S_U_CNT: begin
            total_in = (tot_sum > {1'b0, DIST_MAX}) ? DIST_MAX : tot_sum[33:0];
            state_in = S_U_INC;
         end
         S_U_INC: begin
            cnt_we   = 1'b1;
            e_in     = '0;
            state_in = S_U_RD;
         end
         S_U_RD: state_in = S_U_WR;
         S_U_WR: begin
            sum_we = 1'b1;
            if (e_ff == dim_last_ff) begin
               e_in = '0;
               if (t_ff == ntr_last_ff) begin
                  state_in = S_J_LO;
               end else begin
                  t_in     = t_ff + 1'b1;
                  c_in     = '0;
                  state_in = S_A_RD;
               end
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_U_RD;
            end
         end
         // eps * distortion in two partial products
         S_J_LO: begin
            prod_lo_in = 33'(cfg_eps_ff * total_ff[16:0]);
            pass_in    = pass_ff + 1'b1;
            state_in   = S_J_HI;
         end
         S_J_HI: begin
            prod_hi_in = 33'(cfg_eps_ff * total_ff[33:17]);
            state_in   = S_J_CMP;
         end
         S_J_CMP: begin
            if (conv) begin
               rsp_conv_in = 1'b1;
               rsp_lim_in  = 1'b0;
               state_in    = S_DONE;
            end else if (pass_ff >= lim_ff) begin
               rsp_conv_in = 1'b0;
               rsp_lim_in  = 1'b1;
               state_in    = S_DONE;
            end else begin
               prev_in  = total_ff;
               c_in     = '0;
               e_in     = '0;
               state_in = S_D_CNT;
            end
         end
         S_D_CNT: state_in = S_D_CHK;
         S_D_CHK: begin
            divisor_in = cnt_rd_ff;
            e_in       = '0;
            if (cnt_rd_ff != '0) begin
               state_in = S_D_RD;
            end else if (c_ff == ncw_last_ff) begin
               c_in     = '0;
               total_in = '0;
               state_in = S_CLR;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_D_CNT;
            end
         end
         S_D_RD: state_in = S_D_LD;
         S_D_LD: begin
            quot_in  = sum_rd_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = S_D_DIV;
         end
         // restoring division, one quotient bit per cycle
         S_D_DIV: begin
            if (rem_sh >= {1'b0, divisor_ff}) begin
               rem_in  = CNT_W'(rem_sh - {1'b0, divisor_ff});
               quot_in = {quot_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[CNT_W-1:0];
               quot_in = {quot_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (int'(step_ff) == SUM_W - 1) begin
               state_in = S_D_WR;
            end
         end
         S_D_WR: begin
            cb_we = 1'b1;
            if (e_ff == dim_last_ff) begin
               e_in = '0;
               if (c_ff == ncw_last_ff) begin
                  c_in     = '0;
                  total_in = '0;
                  state_in = S_CLR;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_D_CNT;
               end
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_D_RD;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_elem_in  = 8'd0;
            rsp_dist_in  = total_ff;
            rsp_pass_in  = pass_ff;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_dim_ff   <= RST_VECTOR_DIM;
         cfg_ntr_ff   <= RST_TRAIN_COUNT;
         cfg_ncw_ff   <= RST_CODEWORD_COUNT;
         cfg_eps_ff   <= RST_EPS_Q16;
         cfg_lim_ff   <= RST_MAX_PASSES;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VECTOR_DIM:     cfg_dim_ff <= csr_wdata[4:0];
               CSR_TRAIN_COUNT:    cfg_ntr_ff <= csr_wdata[12:0];
               CSR_CODEWORD_COUNT: cfg_ncw_ff <= csr_wdata[8:0];
               CSR_EPS_Q16:        cfg_eps_ff <= csr_wdata;
               CSR_MAX_PASSES:     cfg_lim_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dim_last_ff <= dim_last_in;
      ntr_last_ff <= ntr_last_in;
      ncw_last_ff <= ncw_last_in;
      lim_ff      <= lim_in;
      e_ff        <= e_in;
      t_ff        <= t_in;
      c_ff        <= c_in;
      best_ff     <= best_in;
      acc_ff      <= acc_in;
      best_d_ff   <= best_d_in;
      total_ff    <= total_in;
      prev_ff     <= prev_in;
      pass_ff     <= pass_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_conv_ff <= rsp_conv_in;
      rsp_lim_ff  <= rsp_lim_in;
   end

   // stores with one write port and one registered read port
   always_ff @(posedge clock) begin
      if (tr_we) begin
         train_mem[tr_waddr] <= req_value;
      end
      tr_rd_ff <= train_mem[tr_raddr];
   end

   always_ff @(posedge clock) begin
      if (cb_we) begin
         cb_mem[cb_waddr] <= cb_wdata;
      end
      cb_rd_ff <= cb_mem[cb_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while the sequencer is busy");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_conv_ff && rsp_lim_ff))
      else $error("run reported both converged and limit");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE || $past(state_ff) == S_RDCB))
      else $error("result raised outside a finishing state");

   a_elem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_ACC || state_ff == S_U_WR || state_ff == S_D_WR)
      |-> (e_ff <= dim_last_ff))
      else $error("element counter ran past the vector length");

endmodule

`default_nettype wire
